/* rtl/rcb_block_split_top_macros.svh */
// Assertion macros for the rcb_block_split blocks.
// Uses clk and rst of the module that includes this file.
`ifndef RCB_BLOCK_SPLIT_TOP_MACROS_SVH
`define RCB_BLOCK_SPLIT_TOP_MACROS_SVH

// same-cycle implication
`define RCB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rcb assertion failed");

// next-cycle implication
`define RCB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rcb assertion failed");

`endif

/* rtl/rcb_pkg.sv */
// Package for the rcb_block_split block: word types, codes, defaults.
// No dependencies.
`default_nettype none
package rcb_pkg;

  localparam int MAX_LEVELS_DEF = 16;
  localparam int COORD_BITS_DEF = 16;
  localparam int CUT_BITS_DEF   = 16;

  localparam int LVL_CNT_W = 5;   // level counter, 5 bits wide, counts up to 31 levels of bisection
  localparam int PART_W    = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 17;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_SHORT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_I     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_J     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_K     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT = 2'd3;

  localparam logic [1:0] AX_I = 2'd0;
  localparam logic [1:0] AX_J = 2'd1;
  localparam logic [1:0] AX_K = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [3:0]  level;
    logic [15:0] cut_fraction;
    logic [15:0] part_index;
  } item_t;

  typedef struct packed {
    logic [15:0] start_i;
    logic [15:0] start_j;
    logic [15:0] start_k;
    logic [15:0] end_i;
    logic [15:0] end_j;
    logic [15:0] end_k;
    logic [1:0]  status;
  } result_t;

  // too_short is for the box presented now, ax is the axis latched at the last pick
  typedef struct packed {
    logic       too_short;
    logic [1:0] ax;
  } split_ctl_t;

endpackage
`default_nettype wire

/* rtl/rcb_cut_mem.sv */
// Per-level cut table: one write port, one registered read port.
// Depends on nothing but its parameters.
`default_nettype none
module rcb_cut_mem #(
  parameter int MAX_LEVELS = 16,
  parameter int CUT_BITS   = 16,
  parameter int LVLW       = 4
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [LVLW-1:0]     waddr,
  input  wire logic [CUT_BITS-1:0] wdata,
  input  wire logic [LVLW-1:0]     raddr,
  output logic      [CUT_BITS-1:0] rdata
);

  logic [CUT_BITS-1:0] mem [MAX_LEVELS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/rcb_split_unit.sv */
// Shared split unit: longest-axis pick, cut multiply, clamp of the offset.
// Depends on rcb_pkg.
`default_nettype none
module rcb_split_unit #(
  parameter int COORD_BITS = 16,
  parameter int CUT_BITS   = 16
) (
  input  wire logic                            clk,
  input  wire logic                            pick,
  input  wire logic [2:0][COORD_BITS-1:0]      lo,
  input  wire logic [2:0][COORD_BITS-1:0]      hi,
  input  wire logic [CUT_BITS-1:0]             cut,
  output rcb_pkg::split_ctl_t                  ctl,
  output logic      [COORD_BITS-1:0]           off
);

  localparam int PW = COORD_BITS + CUT_BITS;

  logic [2:0][COORD_BITS-1:0] d;
  logic [1:0]                 ax_sel;
  logic [COORD_BITS-1:0]      dsel;
  logic [1:0]                 ax;
  logic [COORD_BITS-1:0]      dlen;
  logic [PW-1:0]              prod;
  logic [COORD_BITS-1:0]      off_raw;
  logic [COORD_BITS-1:0]      off_max;

  always_comb begin
    d[0] = hi[0] - lo[0];
    d[1] = hi[1] - lo[1];
    d[2] = hi[2] - lo[2];
    if (d[0] >= d[1] && d[0] >= d[2]) begin
      ax_sel = rcb_pkg::AX_I;
    end else if (d[1] >= d[2]) begin
      ax_sel = rcb_pkg::AX_J;
    end else begin
      ax_sel = rcb_pkg::AX_K;
    end
    dsel = d[ax_sel];
  end

  always_ff @(posedge clk) begin
    if (pick) begin
      ax   <= ax_sel;
      dlen <= dsel;
      prod <= PW'(dsel - COORD_BITS'(1)) * PW'(cut);
    end
  end

  always_comb begin
    off_raw = prod[PW-1:CUT_BITS];
    off_max = dlen - COORD_BITS'(2);
    off     = (off_raw > off_max) ? off_max : off_raw;
    ctl.too_short = (dsel < COORD_BITS'(2));
    ctl.ax        = ax;
  end

endmodule
`default_nettype wire

/* rtl/rcb_block_split_top.sv */
// Recursive coordinate bisection: a load word writes a cut and leaves busy low.
// A query word holds busy through its levels: each level is one pick/multiply
// state and one update state in the shared split unit, and done strobes in a
// DONE state after the last level or a too-short box. Out-of-range parts strobe
// done in the cycle after start. The receiver cannot stall. rst (sync) clears
// the sequencer and the size registers; the cut table is not cleared.
`default_nettype none
module rcb_block_split_top #(
  parameter int MAX_LEVELS = rcb_pkg::MAX_LEVELS_DEF,
  parameter int COORD_BITS = rcb_pkg::COORD_BITS_DEF,
  parameter int CUT_BITS   = rcb_pkg::CUT_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire rcb_pkg::item_t                   item,
  output logic                                  done,
  output rcb_pkg::result_t                      result,
  input  wire logic                             cfg_we,
  input  wire logic [rcb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rcb_pkg::CFG_DAT_W-1:0]    cfg_data
);

  localparam int LVLW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int CW   = COORD_BITS;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PICK   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [15:0]                   grid_i, grid_j, grid_k;
  logic [rcb_pkg::PART_W-1:0]    part_count;

  logic [2:0][CW-1:0]            lo, lo_next, hi, hi_next;
  logic [rcb_pkg::PART_W-1:0]    n, n_next;
  logic [15:0]                   rank, rank_next;
  logic [rcb_pkg::LVL_CNT_W-1:0] lvl, lvl_next;
  logic [1:0]                    status, status_next;

  logic                          load_we;
  logic [LVLW-1:0]               rd_addr;
  logic [CUT_BITS-1:0]           cut_rd;
  rcb_pkg::split_ctl_t           ctl;
  logic [CW-1:0]                 off;
  logic [CW-1:0]                 split_pos;
  logic [rcb_pkg::PART_W-1:0]    half;
  logic                          upper;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_i     <= 16'd1;
      grid_j     <= 16'd1;
      grid_k     <= 16'd1;
      part_count <= 17'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        rcb_pkg::REG_GRID_I:     grid_i     <= cfg_data[15:0];
        rcb_pkg::REG_GRID_J:     grid_j     <= cfg_data[15:0];
        rcb_pkg::REG_GRID_K:     grid_k     <= cfg_data[15:0];
        rcb_pkg::REG_PART_COUNT: part_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy    = (state != ST_IDLE);
  assign load_we = start && !busy && (item.operation == rcb_pkg::OP_LOAD) &&
                   (32'(item.level) < MAX_LEVELS);

  always_comb begin
    if (32'(lvl_next) >= MAX_LEVELS) begin
      rd_addr = LVLW'(MAX_LEVELS - 1);
    end else begin
      rd_addr = LVLW'(lvl_next);
    end
  end

  rcb_cut_mem #(
    .MAX_LEVELS (MAX_LEVELS),
    .CUT_BITS   (CUT_BITS),
    .LVLW       (LVLW)
  ) u_cut_mem (
    .clk   (clk),
    .we    (load_we),
    .waddr (LVLW'(item.level)),
    .wdata (CUT_BITS'(item.cut_fraction)),
    .raddr (rd_addr),
    .rdata (cut_rd)
  );

  rcb_split_unit #(
    .COORD_BITS (COORD_BITS),
    .CUT_BITS   (CUT_BITS)
  ) u_split_unit (
    .clk  (clk),
    .pick (state == ST_PICK),
    .lo   (lo),
    .hi   (hi),
    .cut  (cut_rd),
    .ctl  (ctl),
    .off  (off)
  );

  always_comb begin
    split_pos = lo[ctl.ax] + CW'(1) + off;
    half      = n >> 1;
    upper     = ({1'b0, rank} >= half);
  end

  always_comb begin
    state_next  = state;
    lo_next     = lo;
    hi_next     = hi;
    n_next      = n;
    rank_next   = rank;
    lvl_next    = lvl;
    status_next = status;
    case (state)
      ST_IDLE: begin
        if (start && item.operation == rcb_pkg::OP_QUERY) begin
          lo_next     = '0;
          hi_next[0]  = CW'(grid_i);
          hi_next[1]  = CW'(grid_j);
          hi_next[2]  = CW'(grid_k);
          n_next      = part_count;
          rank_next   = item.part_index;
          lvl_next    = '0;
          status_next = rcb_pkg::STATUS_OK;
          if ({1'b0, item.part_index} >= part_count) begin
            status_next = rcb_pkg::STATUS_RANGE;
            state_next  = ST_DONE;
          end else if (part_count <= 17'd1) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_PICK;
          end
        end
      end
      ST_PICK: begin
        if (ctl.too_short) begin
          status_next = rcb_pkg::STATUS_SHORT;
          state_next  = ST_DONE;
        end else begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (upper) begin
          lo_next[ctl.ax] = split_pos;
          n_next          = n - half;
          rank_next       = rank - half[15:0];
        end else begin
          hi_next[ctl.ax] = split_pos;
          n_next          = half;
        end
        lvl_next   = lvl + rcb_pkg::LVL_CNT_W'(1);
        state_next = (n_next > 17'd1) ? ST_PICK : ST_DONE;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      n      <= 17'd1;
      lvl    <= '0;
      status <= rcb_pkg::STATUS_OK;
    end else begin
      state  <= state_next;
      n      <= n_next;
      lvl    <= lvl_next;
      status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    lo   <= lo_next;
    hi   <= hi_next;
    rank <= rank_next;
  end

  logic box_ok;

  always_comb begin
    box_ok         = (status == rcb_pkg::STATUS_OK);
    done           = (state == ST_DONE);
    result.start_i = box_ok ? 16'(lo[0]) : 16'd0;
    result.start_j = box_ok ? 16'(lo[1]) : 16'd0;
    result.start_k = box_ok ? 16'(lo[2]) : 16'd0;
    result.end_i   = box_ok ? 16'(hi[0]) : 16'd0;
    result.end_j   = box_ok ? 16'(hi[1]) : 16'd0;
    result.end_k   = box_ok ? 16'(hi[2]) : 16'd0;
    result.status  = status;
  end

  `include "rcb_block_split_top_macros.svh"

  `RCB_ASSERT_NEXT(a_done_single, done, !done)
  `RCB_ASSERT_NOW(a_update_after_pick, state == ST_UPDATE, $past(state == ST_PICK))
  `RCB_ASSERT_NOW(a_split_inside, state == ST_UPDATE, split_pos > lo[ctl.ax] && split_pos < hi[ctl.ax])
  `RCB_ASSERT_NEXT(a_query_busy, start && !busy && item.operation == rcb_pkg::OP_QUERY, busy)
  `RCB_ASSERT_NOW(a_group_nonzero, state == ST_PICK || state == ST_UPDATE, n > 17'd1)

endmodule
`default_nettype wire
